### hw/rtl/fspm_pkg.sv
// Package: shared types and constants for the shortest-path matrix unit.
package fspm_pkg;

  localparam int unsigned NODE_W   = 3;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned COST_W   = 19;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Classified request passed from front to back
  typedef struct packed {
    logic              is_query;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [WIN_W-1:0]  weight;
    logic              present;
  } fspm_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_RELAX,
    ST_TRACE,
    ST_EMIT
  } fspm_state_t;

endpackage

### hw/rtl/fifo_shortest_path_matrix_unit.sv
// Top level: shortest-path search over a stored adjacency matrix.
//  channel | dir | contents
//  in_     | in  | edge write or query request
//  out_    | out | one path node per request result, tlast on final node
// An edge write is applied by the back end from idle. A query scans one
// matrix column per cycle for each dequeued node, then traces the path back
// from the destination and emits one result per path node. Reset clears the
// matrix present flags at once. Requests queue in a two-entry buffer while busy.
module fifo_shortest_path_matrix_unit #(
  parameter int unsigned NODES       = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // from_node, to_node, edge_weight_in, edge_present
  input  logic        in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // path_node, total_cost, reachable
  output logic        out_tlast  // last
);
  import fspm_pkg::*;

  fspm_cmd_t cmd;
  logic      cmd_valid, cmd_ready;

  fspm_front #(.DEPTH(2)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .cmd_valid, .cmd_ready, .cmd
  );

  fspm_back #(.NODES(NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

### hw/rtl/fspm_front.sv
// Front end: accepts requests and queues them in a short command queue.
module fspm_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [fspm_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                     in_tuser,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output fspm_pkg::fspm_cmd_t      cmd
);
  import fspm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fspm_cmd_t          q_r [DEPTH];
  logic [PW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]        cnt_r, cnt_nxt;
  fspm_cmd_t          new_cmd;
  logic               push, pop;

  // Classify the incoming request
  always_comb begin
    new_cmd.is_query  = (in_tuser == REQ_QUERY);
    new_cmd.from_node = in_tdata[2:0];
    new_cmd.to_node   = in_tdata[5:3];
    new_cmd.weight    = in_tdata[21:6];
    new_cmd.present   = in_tdata[22];
  end

  assign in_tready = (cnt_r != (PW+1)'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  // Advance pointers
  always_comb begin
    wp_nxt  = push ? ((wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? ((rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= new_cmd;
  end

endmodule

### hw/rtl/fspm_back.sv
// Back end: adjacency matrix, FIFO label-correcting search and path output.
module fspm_back #(
  parameter int unsigned NODES       = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  fspm_pkg::fspm_cmd_t       cmd,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [fspm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import fspm_pkg::*;

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EW = 2 * NW;
  localparam int unsigned DW = WEIGHT_BITS + NW + 1;
  localparam int unsigned CW = NW + 1;

  // Matrix memory and present flags, addressed by {row, column}
  logic [WEIGHT_BITS-1:0] wmem [2**EW];
  logic [2**EW-1:0]       ev_r;
  logic [WEIGHT_BITS-1:0] wrd_r;

  logic [DW-1:0]  dist_r [NODES];
  logic [NODES-1:0] fin_r, pv_r, inq_r;
  logic [NW-1:0]  pred_r [NODES];
  logic [NW-1:0]  wq_r [NODES];
  logic [NW-1:0]  head_r, tail_r;
  logic [CW-1:0]  qcnt_r;

  fspm_state_t    st_r, st_nxt;
  logic [NW-1:0]  src_r, dst_r, cur_r, col_r, node_r;
  logic           rd_ok_r;       // weight read data valid for col_r
  logic [NW-1:0]  chain_r [NODES];
  logic [CW-1:0]  len_r, k_r;
  logic [DW-1:0]  cost_r;
  logic           reach_r;

  logic [NW-1:0]  from_m, to_m;
  logic [NW-1:0]  last_node;
  logic [DW-1:0]  cand;
  logic           better, do_push;
  logic           pop_ev;

  // Reduce a node number into range by repeated subtraction
  function automatic logic [NW-1:0] node_mod(input logic [NODE_W-1:0] x);
    int unsigned v;
    v = 32'(x);
    for (int i = 0; i < 4; i++) begin
      if (v >= NODES) v = v - NODES;
    end
    return NW'(v);
  endfunction

  assign from_m = node_mod(cmd.from_node);
  assign to_m   = node_mod(cmd.to_node);
  assign last_node = NW'(NODES-1);

  assign cmd_ready = (st_r == ST_IDLE) && !out_tvalid;

  // Candidate distance for the column under scan
  assign cand   = dist_r[cur_r] + DW'(wrd_r);
  assign better = rd_ok_r && ev_r[{cur_r, col_r}] &&
                  (!fin_r[col_r] || cand < dist_r[col_r]);
  assign do_push = better && !inq_r[col_r] && col_r != src_r && col_r != dst_r;
  assign pop_ev  = (st_r == ST_POP) && (qcnt_r != '0);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (cmd_valid && cmd_ready && cmd.is_query) st_nxt = ST_POP;
      ST_POP:   if (qcnt_r == '0) st_nxt = ST_TRACE;
                else if (fin_r[wq_r[head_r]]) st_nxt = ST_RELAX;
      ST_RELAX: if (rd_ok_r && col_r == last_node) st_nxt = ST_POP;
      ST_TRACE: if (!pv_r[node_r] || len_r == CW'(NODES)) st_nxt = ST_EMIT;
      ST_EMIT:  if (out_tvalid && out_tready && out_tlast) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Output drive
  always_comb begin
    out_tvalid = (st_r == ST_EMIT);
    out_tlast  = (k_r + 1'b1 == len_r);
    out_tdata  = '0;
    out_tdata[NODE_W-1:0] = NODE_W'(chain_r[NW'(len_r - 1'b1 - k_r)]);
    out_tdata[NODE_W +: COST_W] = COST_W'(cost_r);
    out_tdata[NODE_W+COST_W]    = reach_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ev_r  <= '0;
      fin_r <= '0;
      pv_r  <= '0;
      inq_r <= '0;
      qcnt_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && cmd_valid && cmd_ready) begin
        if (!cmd.is_query) begin
          ev_r[{from_m, to_m}] <= cmd.present;
        end else begin
          fin_r  <= NODES'(1) << from_m;
          pv_r   <= '0;
          inq_r  <= NODES'(1) << from_m;
          head_r <= '0;
          tail_r <= NW'(1 % NODES);
          qcnt_r <= CW'(1);
        end
      end
      // Pop one node
      if (pop_ev) begin
        head_r <= (head_r == last_node) ? '0 : head_r + 1'b1;
        inq_r[wq_r[head_r]] <= 1'b0;
        rd_ok_r <= 1'b0;
      end
      if (st_r == ST_RELAX) begin
        rd_ok_r <= !(rd_ok_r && col_r == last_node);
        if (better) begin
          fin_r[col_r] <= 1'b1;
          pv_r[col_r]  <= 1'b1;
        end
        if (do_push) begin
          inq_r[col_r] <= 1'b1;
          tail_r <= (tail_r == last_node) ? '0 : tail_r + 1'b1;
        end
        qcnt_r <= qcnt_r + CW'(do_push);
      end else if (pop_ev) begin
        qcnt_r <= qcnt_r - 1'b1;
      end
    end
  end

  // Payload and search data
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && cmd_valid && cmd_ready) begin
      if (!cmd.is_query) begin
        wmem[{from_m, to_m}] <= WEIGHT_BITS'(cmd.weight);
      end else begin
        src_r <= from_m;
        dst_r <= to_m;
        dist_r[from_m] <= '0;
        wq_r[0] <= from_m;
      end
    end
    if (pop_ev) begin
      cur_r <= wq_r[head_r];
      col_r <= '0;
    end
    // Relax one column per cycle after the read latency
    if (st_r == ST_RELAX) begin
      wrd_r <= wmem[{cur_r, (rd_ok_r ? col_r + 1'b1 : col_r)}];
      if (rd_ok_r) col_r <= col_r + 1'b1;
      if (better) begin
        dist_r[col_r] <= cand;
        pred_r[col_r] <= cur_r;
      end
      if (do_push) wq_r[tail_r] <= col_r;
    end
    if (st_r == ST_POP && qcnt_r == '0) begin
      node_r <= dst_r;
      chain_r[0] <= dst_r;
      len_r <= CW'(1);
      k_r <= '0;
      reach_r <= fin_r[dst_r];
      cost_r <= fin_r[dst_r] ? dist_r[dst_r] : '0;
    end
    if (st_r == ST_TRACE && pv_r[node_r] && len_r != CW'(NODES)) begin
      node_r <= pred_r[node_r];
      chain_r[NW'(len_r)] <= pred_r[node_r];
      len_r <= len_r + 1'b1;
    end
    if (st_r == ST_EMIT && out_tready) k_r <= k_r + 1'b1;
  end

endmodule

### tb/sv/tb_fifo_shortest_path_matrix_unit.sv
// Testbench for the shortest-path matrix unit: directed table, then random graphs and queries.
module tb_fifo_shortest_path_matrix_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fspm_pkg::*;

  localparam int unsigned N_NODES = 8;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] cost;
    logic              reach;
    logic              last;
  } path_step_t;

  typedef struct {
    logic              kind;
    logic [NODE_W-1:0] from_n;
    logic [NODE_W-1:0] to_n;
    logic [WIN_W-1:0]  weight;
    logic              present;
    int                want_len;   // -1: predictor only
    logic [COST_W-1:0] want_cost;
    logic              want_reach;
  } request_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // Own copy of the matrix
  logic [WIN_W-1:0] edge_weight [N_NODES*N_NODES];
  logic             edge_on     [N_NODES*N_NODES];

  path_step_t path_q[$];
  int         errors;
  int         cycles;
  bit         idle_on;
  bit         tail_phase;

  fifo_shortest_path_matrix_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fifo_shortest_path_matrix_unit: done, errors");
      $finish;
    end
  end

  // Label-correcting search, then queue the path from source to destination
  task automatic predict_path(input int src, input int dst);
    logic [19:0] node_dist [N_NODES];
    logic        fin  [N_NODES];
    int          pred [N_NODES];
    logic        pv   [N_NODES];
    int          fifo_q[$];
    logic [N_NODES-1:0] queued;
    int          chain[$];
    int          cur;
    int          nd;
    logic [19:0] cand;
    path_step_t  s;
    for (int i = 0; i < N_NODES; i++) begin
      node_dist[i] = '0; fin[i] = 1'b0; pred[i] = 0; pv[i] = 1'b0;
    end
    queued = '0;
    fin[src] = 1'b1;
    fifo_q.push_back(src);
    queued[src] = 1'b1;
    while (fifo_q.size() != 0) begin
      cur = fifo_q.pop_front();
      queued[cur] = 1'b0;
      if (!fin[cur]) continue;
      for (int i = 0; i < N_NODES; i++) begin
        if (!edge_on[cur*N_NODES+i]) continue;
        cand = node_dist[cur] + 20'(edge_weight[cur*N_NODES+i]);
        if (!fin[i] || cand < node_dist[i]) begin
          node_dist[i] = cand; fin[i] = 1'b1; pred[i] = cur; pv[i] = 1'b1;
          if (!queued[i] && i != src && i != dst) begin
            fifo_q.push_back(i);
            queued[i] = 1'b1;
          end
        end
      end
    end
    nd = dst;
    chain.push_front(nd);
    while (pv[nd] && chain.size() < N_NODES) begin
      nd = pred[nd];
      chain.push_front(nd);
    end
    foreach (chain[k]) begin
      s.node  = NODE_W'(chain[k]);
      s.cost  = fin[dst] ? node_dist[dst][COST_W-1:0] : '0;
      s.reach = fin[dst];
      s.last  = (k == chain.size() - 1);
      path_q.push_back(s);
    end
  endtask

  // Drive one request, update the model on acceptance
  task automatic send_request(input request_row_t r);
    int first;
    if (idle_on && !tail_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {1'b0, r.present, r.weight, r.to_n, r.from_n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (r.kind == REQ_EDGE) begin
      edge_weight[r.from_n*N_NODES+r.to_n] = r.weight;
      edge_on[r.from_n*N_NODES+r.to_n]     = r.present;
    end else begin
      first = path_q.size();
      predict_path(r.from_n, r.to_n);
      if (r.want_len >= 0) begin
        if (path_q.size() - first != r.want_len ||
            path_q[first].cost != r.want_cost || path_q[first].reach != r.want_reach) begin
          $display("%0t: table row mismatch: expected len %0d cost %0d reach %0b, got %0d %0d %0b",
                   $time, r.want_len, r.want_cost, r.want_reach, path_q.size() - first,
                   path_q[first].cost, path_q[first].reach);
          errors++;
        end
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    path_step_t got;
    path_step_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[NODE_W-1:0], out_tdata[NODE_W+COST_W-1:NODE_W],
             out_tdata[NODE_W+COST_W], out_tlast};
      if (path_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = path_q.pop_front();
        if (got.node !== want.node) begin
          $display("%0t: path_node expected %0d actual %0d", $time, want.node, got.node);
          errors++;
        end
        if (got.cost !== want.cost) begin
          $display("%0t: total_cost expected %0d actual %0d", $time, want.cost, got.cost);
          errors++;
        end
        if (got.reach !== want.reach) begin
          $display("%0t: reachable expected %0b actual %0b", $time, want.reach, got.reach);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Receiver stalls in bursts
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && !tail_phase && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic request_row_t mk(input logic k, input int a, input int b,
                                      input int w, input logic p, input int len,
                                      input int c, input logic rch);
    request_row_t r;
    r.kind = k; r.from_n = NODE_W'(a); r.to_n = NODE_W'(b); r.weight = WIN_W'(w);
    r.present = p;
    r.want_len = len; r.want_cost = COST_W'(c); r.want_reach = rch;
    return r;
  endfunction

  request_row_t dir_rows[$];
  request_row_t r;
  int           n_items;

  initial begin
    errors = 0; cycles = 0; idle_on = 1'b0; tail_phase = 1'b0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = REQ_EDGE;
    foreach (edge_on[i]) begin
      edge_on[i] = 1'b0; edge_weight[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty graph, self query, chains, max weights, removal
    dir_rows.push_back(mk(REQ_QUERY, 0, 7, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 3, 3, 0, 0, 1, 0, 1));
    dir_rows.push_back(mk(REQ_EDGE, 0, 1, 16'hFFFF, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 1, 2, 16'hFFFF, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 2, 3, 16'hFFFF, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 0, 3, 0, 0, 4, 196605, 1));
    dir_rows.push_back(mk(REQ_EDGE, 3, 4, 16'hFFFF, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 4, 5, 16'hFFFF, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 5, 6, 16'hFFFF, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 6, 7, 16'hFFFF, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 0, 7, 0, 0, 8, 458745, 1));
    dir_rows.push_back(mk(REQ_QUERY, 7, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 0, 7, 5, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 0, 7, 0, 0, 2, 5, 1));
    dir_rows.push_back(mk(REQ_EDGE, 7, 0, 0, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 7, 7, 0, 0, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 7, 3, 0, 0, -1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 0, 7, 5, 0, -1, 0, 0));
    dir_rows.push_back(mk(REQ_EDGE, 2, 2, 0, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 0, 7, 0, 0, 8, 458745, 1));
    dir_rows.push_back(mk(REQ_EDGE, 1, 6, 0, 1, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 0, 7, 0, 0, -1, 0, 0));
    dir_rows.push_back(mk(REQ_QUERY, 6, 1, 0, 0, -1, 0, 0));
    foreach (dir_rows[i]) send_request(dir_rows[i]);

    // Hold the sender until every path has drained
    in_tvalid <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    idle_on = 1'b1;

    // Random: mostly edge writes with queries mixed in at random, some edge removals
    n_items = 0;
    while (n_items < 470) begin
      if (n_items > 400) tail_phase = 1'b1;
      r.kind    = ($urandom_range(0, 2) == 0) ? REQ_QUERY : REQ_EDGE;
      r.from_n  = NODE_W'($urandom_range(0, 7));
      r.to_n    = NODE_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       r.weight = WIN_W'($urandom_range(0, 15));
        1:       r.weight = WIN_W'(16'hFFFF - $urandom_range(0, 15));
        default: r.weight = WIN_W'($urandom);
      endcase
      r.present  = ($urandom_range(0, 3) != 0);
      r.want_len = -1;
      send_request(r);
      n_items++;
    end
    in_tvalid <= 1'b0;

    // Drain, then allow the back end to settle
    while (path_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fifo_shortest_path_matrix_unit: done, clean");
    end else begin
      $display("tb_fifo_shortest_path_matrix_unit: done, errors");
    end
    $finish;
  end

endmodule
